// ===== design/rpn_stack_evaluator_assert.svh =====
// Assertion macros used by the checker of the RPN stack evaluator.
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH

// Same-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define RSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rse_pkg.sv =====
// Shared types, codes and constants of the RPN stack evaluator.
`timescale 1ns / 1ps

package rse_pkg;

    // Default sizes handed to the top level parameters.
    localparam int unsigned STACK_DEPTH_DEF = 16;
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    // Character codes of the expression alphabet.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_INVALID  = 3'd2,
        ST_FEW      = 3'd3,
        ST_DIVZERO  = 3'd4,
        ST_COUNT    = 3'd5,
        ST_OVERFLOW = 3'd6
    } t_status;

    // Operator kinds.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_WAIT,
        S_FINISH
    } t_state;

    // Input word: one character of the expression.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_only;
        logic       last;
    } t_in_word;

    // Output word: one evaluation result.
    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    mark_saw;
        logic    mark_invalid;
        logic    err_load;
        t_status err_code;
        logic    push_digit;
        logic    rd_en;
        logic    wr_addsub;
        logic    drop_two;
        logic    arith_start;
        logic    wr_arith;
        logic    emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic end_only;
        logic last;
        logic is_space;
        logic is_digit;
        logic is_op;
        t_op  op;
        logic err_active;
        logic stack_full;
        logic fewer_than_two;
        logic rhs_zero;
        logic arith_done;
        logic out_busy;
    } t_sts;

endpackage

// ===== design/rse_muldiv.sv =====
// Bit-serial multiplier and restoring signed divider shared by * and /.
`timescale 1ns / 1ps

module rse_muldiv #(
    parameter int unsigned W = rse_pkg::VALUE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_is_div,
    input  logic [W-1:0] i_lhs,
    input  logic [W-1:0] i_rhs,
    output logic         o_done,
    output logic [W-1:0] o_result
);

    localparam int unsigned NW = $clog2(W + 1);

    logic          r_busy;
    logic [NW-1:0] r_cnt;
    logic          r_is_div;
    logic          r_neg;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_rem;

    logic [W-1:0]  lhs_mag;
    logic [W-1:0]  rhs_mag;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          stepping;

    // Operand magnitudes and one restoring-division step.
    always_comb begin
        lhs_mag  = i_lhs[W-1] ? (~i_lhs + W'(1)) : i_lhs;
        rhs_mag  = i_rhs[W-1] ? (~i_rhs + W'(1)) : i_rhs;
        rem_sh   = {r_rem, r_a[W-1]};
        diff     = rem_sh - {1'b0, r_b};
        stepping = r_busy && (r_cnt != NW'(W));
        o_done   = r_busy && (r_cnt == NW'(W));
    end

    // The quotient takes the sign of the operands; the product is the accumulator.
    assign o_result = r_is_div ? (r_neg ? (~r_a + W'(1)) : r_a) : r_acc;

    // Busy flag and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (stepping) begin
            r_cnt  <= r_cnt + NW'(1);
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // One bit of the product or the quotient per cycle.
    // The partial remainder stays below the divisor, so it fits in W bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_is_div <= i_is_div;
            r_neg    <= i_lhs[W-1] ^ i_rhs[W-1];
            r_acc    <= '0;
            r_rem    <= '0;
            r_a      <= i_is_div ? lhs_mag : i_lhs;
            r_b      <= i_is_div ? rhs_mag : i_rhs;
        end else if (stepping) begin
            if (r_is_div) begin
                if (!diff[W]) begin
                    r_rem <= diff[W-1:0];
                    r_a   <= {r_a[W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[W-1:0];
                    r_a   <= {r_a[W-2:0], 1'b0};
                end
            end else begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= {r_a[W-2:0], 1'b0};
                r_b <= {1'b0, r_b[W-1:1]};
            end
        end
    end

endmodule

// ===== design/rse_datapath.sv =====
// Datapath: operand stack memory, status flags, arithmetic and result register.
`timescale 1ns / 1ps

module rse_datapath #(
    parameter int unsigned STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
    parameter int unsigned VALUE_WIDTH = rse_pkg::VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rse_pkg::t_in_word i_in_word,
    input  rse_pkg::t_cmd     i_cmd,
    output rse_pkg::t_sts     o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rse_pkg::t_out_word o_out_word
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    logic [VALUE_WIDTH-1:0] r_stack [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] r_rhs;
    logic [VALUE_WIDTH-1:0] r_lhs;
    logic [VALUE_WIDTH-1:0] r_bottom;
    rse_pkg::t_in_word      r_word;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_saw;
    logic                   r_invalid;
    rse_pkg::t_status       r_err;
    logic                   r_out_valid;
    rse_pkg::t_out_word     r_out;

    logic [7:0]             code;
    logic [7:0]             digit8;
    logic [AW-1:0]          addr_m1;
    logic [AW-1:0]          addr_m2;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [VALUE_WIDTH-1:0] addsub;
    logic [VALUE_WIDTH-1:0] arith_result;
    logic                   arith_done;
    rse_pkg::t_status       final_status;
    logic signed [63:0]     bottom_ext;

    // Character classification of the captured word.
    always_comb begin
        code             = r_word.char_code;
        digit8           = code - rse_pkg::CH_ZERO;
        o_sts            = '0;
        o_sts.end_only   = r_word.end_only;
        o_sts.last       = r_word.last;
        o_sts.is_space   = (code == rse_pkg::CH_SPACE);
        o_sts.is_digit   = (code >= rse_pkg::CH_ZERO) && (code <= rse_pkg::CH_NINE);
        o_sts.is_op      = (code == rse_pkg::CH_PLUS) || (code == rse_pkg::CH_MINUS) ||
                           (code == rse_pkg::CH_STAR) || (code == rse_pkg::CH_SLASH);
        if (code == rse_pkg::CH_MINUS) begin
            o_sts.op = rse_pkg::OP_SUB;
        end else if (code == rse_pkg::CH_STAR) begin
            o_sts.op = rse_pkg::OP_MUL;
        end else if (code == rse_pkg::CH_SLASH) begin
            o_sts.op = rse_pkg::OP_DIV;
        end else begin
            o_sts.op = rse_pkg::OP_ADD;
        end
        o_sts.err_active     = (r_err != rse_pkg::ST_OK);
        o_sts.stack_full     = (r_count == CW'(STACK_DEPTH));
        o_sts.fewer_than_two = (r_count < CW'(2));
        o_sts.rhs_zero       = (r_rhs == '0);
        o_sts.arith_done     = arith_done;
        o_sts.out_busy       = r_out_valid && !i_out_ready;
    end

    // Stack addressing and the single write port.
    always_comb begin
        addr_m1 = AW'(r_count - CW'(1));
        addr_m2 = AW'(r_count - CW'(2));
        addsub  = (o_sts.op == rse_pkg::OP_SUB) ? (r_lhs - r_rhs) : (r_lhs + r_rhs);
        wr_en   = i_cmd.push_digit || i_cmd.wr_addsub || i_cmd.wr_arith;
        wr_addr = i_cmd.push_digit ? r_count[AW-1:0] : addr_m2;
        if (i_cmd.push_digit) begin
            wr_data = VALUE_WIDTH'(digit8);
        end else if (i_cmd.wr_addsub) begin
            wr_data = addsub;
        end else begin
            wr_data = arith_result;
        end
    end

    // Operand stack memory with registered reads of the top two entries.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rhs <= r_stack[addr_m1];
            r_lhs <= r_stack[addr_m2];
        end
    end

    // Copy of the bottom entry, which holds the result when one value remains.
    always_ff @(posedge i_clk) begin
        if (wr_en && (wr_addr == '0)) begin
            r_bottom <= wr_data;
        end
    end

    // Captured input word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_word <= i_in_word;
        end
    end

    // Stack count update.
    always_comb begin
        priority if (i_cmd.emit) begin
            n_count = '0;
        end else if (i_cmd.push_digit) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.wr_addsub || i_cmd.wr_arith) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.drop_two) begin
            n_count = r_count - CW'(2);
        end else begin
            n_count = r_count;
        end
    end

    // Count and expression flags; a result clears them for the next expression.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_saw     <= 1'b0;
            r_invalid <= 1'b0;
            r_err     <= rse_pkg::ST_OK;
        end else begin
            r_count <= n_count;
            if (i_cmd.emit) begin
                r_saw     <= 1'b0;
                r_invalid <= 1'b0;
                r_err     <= rse_pkg::ST_OK;
            end else begin
                if (i_cmd.mark_saw) begin
                    r_saw <= 1'b1;
                end
                if (i_cmd.mark_invalid) begin
                    r_invalid <= 1'b1;
                end
                if (i_cmd.err_load) begin
                    r_err <= i_cmd.err_code;
                end
            end
        end
    end

    // Final status by priority, and the value sign-extended to the output width.
    always_comb begin
        bottom_ext = 64'(signed'(r_bottom));
        priority if (!r_saw) begin
            final_status = rse_pkg::ST_EMPTY;
        end else if (r_invalid) begin
            final_status = rse_pkg::ST_INVALID;
        end else if (r_err != rse_pkg::ST_OK) begin
            final_status = r_err;
        end else if (r_count != CW'(1)) begin
            final_status = rse_pkg::ST_COUNT;
        end else begin
            final_status = rse_pkg::ST_OK;
        end
    end

    // Result register, so the next word can enter while a result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.status <= final_status;
            r_out.value  <= (final_status == rse_pkg::ST_OK) ? bottom_ext[31:0] : 32'sd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Shared iterative unit for multiply and divide.
    rse_muldiv #(
        .W (VALUE_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.arith_start),
        .i_is_div (o_sts.op == rse_pkg::OP_DIV),
        .i_lhs    (r_lhs),
        .i_rhs    (r_rhs),
        .o_done   (arith_done),
        .o_result (arith_result)
    );

endmodule

// ===== design/rse_controller.sv =====
// Controller: sequences one character word through decode, stack access and arithmetic.
`timescale 1ns / 1ps

module rse_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rse_pkg::t_sts i_sts,
    output rse_pkg::t_cmd o_cmd
);

    rse_pkg::t_state r_state;
    rse_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rse_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = rse_pkg::S_DECODE;
                end
            end
            rse_pkg::S_DECODE: begin
                n_state = rse_pkg::S_FINISH;
                if (!i_sts.end_only) begin
                    o_cmd.mark_saw = 1'b1;
                    priority if (i_sts.is_space) begin
                        n_state = rse_pkg::S_FINISH;
                    end else if (!i_sts.is_digit && !i_sts.is_op) begin
                        o_cmd.mark_invalid = 1'b1;
                    end else if (i_sts.err_active) begin
                        n_state = rse_pkg::S_FINISH;
                    end else if (i_sts.is_digit) begin
                        if (i_sts.stack_full) begin
                            o_cmd.err_load = 1'b1;
                            o_cmd.err_code = rse_pkg::ST_OVERFLOW;
                        end else begin
                            o_cmd.push_digit = 1'b1;
                        end
                    end else if (i_sts.fewer_than_two) begin
                        o_cmd.err_load = 1'b1;
                        o_cmd.err_code = rse_pkg::ST_FEW;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        n_state     = rse_pkg::S_READ;
                    end
                end
            end
            rse_pkg::S_READ: begin
                // Operands are now registered; add and subtract finish here.
                n_state = rse_pkg::S_FINISH;
                if ((i_sts.op == rse_pkg::OP_ADD) || (i_sts.op == rse_pkg::OP_SUB)) begin
                    o_cmd.wr_addsub = 1'b1;
                end else if ((i_sts.op == rse_pkg::OP_DIV) && i_sts.rhs_zero) begin
                    o_cmd.drop_two = 1'b1;
                    o_cmd.err_load = 1'b1;
                    o_cmd.err_code = rse_pkg::ST_DIVZERO;
                end else begin
                    o_cmd.arith_start = 1'b1;
                    n_state           = rse_pkg::S_WAIT;
                end
            end
            rse_pkg::S_WAIT: begin
                if (i_sts.arith_done) begin
                    o_cmd.wr_arith = 1'b1;
                    n_state        = rse_pkg::S_FINISH;
                end
            end
            rse_pkg::S_FINISH: begin
                // A last word loads the result register once it is free.
                if (!i_sts.last) begin
                    n_state = rse_pkg::S_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = rse_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rse_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/rpn_stack_evaluator.sv =====
// Top level of the RPN stack evaluator: controller and datapath.
`timescale 1ns / 1ps

// Evaluates a reverse Polish expression sent one character word at a time over a
// valid/ready channel; the word marked last produces one result word holding the
// value and a status code, after which the stack is empty again. Words are taken
// one at a time: each word passes through decode before the next is accepted;
// + and - read their two operands through a registered read of the stack
// memory, and * and / do the same and then wait on the shared unit that forms
// one bit of the product or quotient per cycle. A division by zero ends
// without starting that unit, and an operator that finds fewer than two
// operands or follows an evaluation error ends at decode. The result sits in
// an output register, so the next expression can start while a result waits
// to be taken; a further last word waits only if that register is still full.
module rpn_stack_evaluator #(
    parameter int unsigned STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
    parameter int unsigned VALUE_WIDTH = rse_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rse_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rse_pkg::t_out_word o_out_word
);

    rse_pkg::t_cmd cmd;
    rse_pkg::t_sts sts;

    // Sequencing.
    rse_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Stack, flags and arithmetic.
    rse_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== design/rse_checker.sv =====
// Port-level checker of the RPN stack evaluator and its bind to the top level.
`timescale 1ns / 1ps
`include "rpn_stack_evaluator_assert.svh"

module rse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input rse_pkg::t_out_word i_out_word
);

    // Status codes stay within the defined set.
    `RSE_ASSERT_NOW(a_status_range, i_out_valid, i_out_word.status <= 3'(rse_pkg::ST_OVERFLOW), "status code out of range")

    // Only an ok result carries a value.
    `RSE_ASSERT_NOW(a_value_zero, i_out_valid && (i_out_word.status != 3'(rse_pkg::ST_OK)), i_out_word.value == 32'sd0, "nonzero value with error status")

    // Ready is high only while the controller is idle, so it drops after each acceptance.
    `RSE_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "ready high right after acceptance")

    // A waiting result holds until it is taken.
    `RSE_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word), "result changed while stalled")

endmodule

bind rpn_stack_evaluator rse_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_word  (o_out_word)
);

// ===== tb/sv/tb_rpn_stack_evaluator.sv =====
// Self-checking testbench for the RPN stack evaluator with a built-in expression predictor.
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator;
    import rse_pkg::*;

    localparam int STACK_SLOTS     = STACK_DEPTH_DEF;
    localparam int WORD_TARGET     = 1875;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int DRAIN_CYCLES    = 80;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    // Words waiting to be driven, and results the predictor expects next.
    t_in_word  pending_words[$];
    t_out_word expected_results[$];
    logic [7:0] expr_chars[$];
    int        word_count     = 0;
    int        mismatch_count = 0;

    // Predictor copy of the evaluator state.
    logic [31:0] stk_mem[STACK_SLOTS];
    int          stk_level     = 0;
    logic        chars_seen    = 1'b0;
    logic        bad_char_seen = 1'b0;
    t_status     eval_err      = ST_OK;

    // Sender burst shaping and receiver stall pattern.
    int          burst_left      = 0;
    int          gap_left        = 0;
    logic [31:0] ready_pattern   = '0;
    int          ready_bits_left = 0;
    int          idle_cycles     = 0;

    rpn_stack_evaluator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Applies one accepted word to the predictor; a word marked last yields a result.
    function automatic void rpn_predict(input t_in_word w);
        logic [7:0]      c;
        logic            is_op;
        logic            is_digit;
        logic [31:0]     lhs;
        logic [31:0]     rhs;
        logic [31:0]     res;
        longint          sl;
        longint          sr;
        longint unsigned ml;
        longint unsigned mr;
        longint unsigned quo;
        t_out_word       r;
        c        = w.char_code;
        is_op    = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (!w.end_only) begin
            chars_seen = 1'b1;
            if (c != CH_SPACE) begin
                if (!is_op && !is_digit) begin
                    bad_char_seen = 1'b1;
                end else if (eval_err == ST_OK) begin
                    if (is_digit) begin
                        if (stk_level >= STACK_SLOTS) begin
                            eval_err = ST_OVERFLOW;
                        end else begin
                            stk_mem[stk_level] = {24'd0, c - CH_ZERO};
                            stk_level++;
                        end
                    end else if (stk_level < 2) begin
                        eval_err = ST_FEW;
                    end else begin
                        rhs = stk_mem[stk_level - 1];
                        lhs = stk_mem[stk_level - 2];
                        stk_level -= 2;
                        if (c == CH_SLASH && rhs == 32'd0) begin
                            // Both operands are gone even though nothing is pushed.
                            eval_err = ST_DIVZERO;
                        end else begin
                            case (c)
                                CH_PLUS:  res = lhs + rhs;
                                CH_MINUS: res = lhs - rhs;
                                CH_STAR:  res = lhs * rhs;
                                default: begin
                                    // Divide magnitudes and fix the sign, so the most
                                    // negative value over minus one wraps to itself.
                                    sl  = $signed(lhs);
                                    sr  = $signed(rhs);
                                    ml  = (sl < 0) ? -sl : sl;
                                    mr  = (sr < 0) ? -sr : sr;
                                    quo = ml / mr;
                                    if ((sl < 0) != (sr < 0)) quo = -quo;
                                    res = quo[31:0];
                                end
                            endcase
                            stk_mem[stk_level] = res;
                            stk_level++;
                        end
                    end
                end
            end
        end
        if (w.last) begin
            r.value = '0;
            if (!chars_seen) begin
                r.status = ST_EMPTY;
            end else if (bad_char_seen) begin
                r.status = ST_INVALID;
            end else if (eval_err != ST_OK) begin
                r.status = eval_err;
            end else if (stk_level != 1) begin
                r.status = ST_COUNT;
            end else begin
                r.status = ST_OK;
                r.value  = stk_mem[0];
            end
            expected_results.push_back(r);
            stk_level     = 0;
            chars_seen    = 1'b0;
            bad_char_seen = 1'b0;
            eval_err      = ST_OK;
        end
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Queues one word; end-only words without last are ignored by the block and not counted.
    task automatic push_word(input logic [7:0] c, input logic eo, input logic lst);
        t_in_word w;
        w.char_code = c;
        w.end_only  = eo;
        w.last      = lst;
        pending_words.push_back(w);
        if (!eo || lst) word_count++;
    endtask

    // Builds a well-formed expression with the given number of digits.
    task automatic build_wellformed(input int n_digits);
        int depth;
        int pushed;
        depth  = 0;
        pushed = 0;
        while (pushed < n_digits || depth > 1) begin
            if (pushed < n_digits && (depth < 2 || $urandom_range(0, 1) == 1)) begin
                expr_chars.push_back(rand_digit());
                pushed++;
                depth++;
            end else begin
                expr_chars.push_back(rand_op());
                depth--;
            end
        end
    endtask

    // Sends the built expression with random spaces and ignored words, then ends it.
    task automatic flush_expr();
        int   n;
        logic end_on_char;
        n           = expr_chars.size();
        end_on_char = 1'($urandom_range(0, 1));
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 24) == 0) push_word(8'($urandom), 1'b1, 1'b0);
            if ($urandom_range(0, 4) == 0) push_word(CH_SPACE, 1'b0, 1'b0);
            push_word(expr_chars[k], 1'b0, end_on_char && (k == n - 1));
        end
        if (n == 0 || !end_on_char) push_word(8'($urandom), 1'b1, 1'b1);
        expr_chars.delete();
    endtask

    // Stimulus, reset and end of run.
    initial begin
        int sel;
        int n;
        // Empty expression; the character field of an end-only word is ignored.
        push_word(8'hFF, 1'b1, 1'b1);
        // An end-only word without last does nothing; spaces alone leave no value.
        push_word(8'h00, 1'b1, 1'b0);
        push_word(CH_SPACE, 1'b0, 1'b1);
        // Subtraction, marked on the operator.
        push_word(CH_ZERO + 8'd9, 1'b0, 1'b0);
        push_word(CH_ZERO + 8'd7, 1'b0, 1'b0);
        push_word(CH_MINUS, 1'b0, 1'b1);
        // Addition, closed by an end-only word.
        push_word(CH_ZERO + 8'd3, 1'b0, 1'b0);
        push_word(CH_ZERO + 8'd4, 1'b0, 1'b0);
        push_word(CH_PLUS, 1'b0, 1'b0);
        push_word(8'h00, 1'b1, 1'b1);
        // Multiplication.
        push_word(CH_ZERO + 8'd6, 1'b0, 1'b0);
        push_word(CH_ZERO + 8'd7, 1'b0, 1'b0);
        push_word(CH_STAR, 1'b0, 1'b1);
        // A negative divisor: the quotient truncates toward zero.
        push_word(CH_ZERO + 8'd7, 1'b0, 1'b0);
        push_word(CH_ZERO, 1'b0, 1'b0);
        push_word(CH_ZERO + 8'd2, 1'b0, 1'b0);
        push_word(CH_MINUS, 1'b0, 1'b0);
        push_word(CH_SLASH, 1'b0, 1'b1);
        // Division by zero.
        push_word(CH_ZERO + 8'd5, 1'b0, 1'b0);
        push_word(CH_ZERO, 1'b0, 1'b0);
        push_word(CH_SLASH, 1'b0, 1'b1);
        // A lone operator has too few operands.
        push_word(CH_PLUS, 1'b0, 1'b1);
        // Code 0 and code 255 are both invalid characters.
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b1);
        // Two values left on the stack.
        push_word(CH_ZERO + 8'd1, 1'b0, 1'b0);
        push_word(CH_ZERO + 8'd2, 1'b0, 1'b1);

        // Random expressions, mostly well formed.
        while (word_count < WORD_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 64) begin
                build_wellformed(($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 6));
            end else if (sel < 70) begin
                // Deep stack: filling all slots is fine, one more digit overflows.
                n = $urandom_range(15, 18);
                repeat (n) expr_chars.push_back(rand_digit());
                repeat (n - 1) expr_chars.push_back(rand_op());
            end else if (sel < 75) begin
                // 8 to the tenth times 2 wraps to the most negative value.
                expr_chars.push_back(CH_ZERO + 8'd8);
                repeat (9) begin
                    expr_chars.push_back(CH_ZERO + 8'd8);
                    expr_chars.push_back(CH_STAR);
                end
                expr_chars.push_back(CH_ZERO + 8'd2);
                expr_chars.push_back(CH_STAR);
                case ($urandom_range(0, 2))
                    0: begin
                        expr_chars.push_back(CH_ZERO);
                        expr_chars.push_back(CH_ZERO + 8'd1);
                        expr_chars.push_back(CH_MINUS);
                        expr_chars.push_back(CH_SLASH);
                    end
                    1: begin
                        expr_chars.push_back(CH_ZERO + 8'd1);
                        expr_chars.push_back(CH_MINUS);
                    end
                    default: begin
                        expr_chars.push_back(CH_ZERO + 8'd9);
                        expr_chars.push_back(CH_STAR);
                    end
                endcase
            end else if (sel < 88) begin
                // A well-formed expression with one word broken.
                build_wellformed($urandom_range(1, 6));
                n = $urandom_range(0, expr_chars.size());
                case ($urandom_range(0, 2))
                    0: expr_chars.insert(n, 8'($urandom));
                    1: expr_chars.insert(n, rand_op());
                    default: expr_chars.delete($urandom_range(0, expr_chars.size() - 1));
                endcase
            end else begin
                // Noise: random codes with some alphabet characters mixed in.
                repeat ($urandom_range(0, 10)) begin
                    case ($urandom_range(0, 5))
                        0: expr_chars.push_back(rand_op());
                        1: expr_chars.push_back(rand_digit());
                        default: expr_chars.push_back(8'($urandom));
                    endcase
                end
            end
            flush_expr();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Driver: bursts of words separated by random gaps.
    always @(posedge clk) begin
        logic     fire;
        logic     nxt_valid;
        t_in_word nxt_word;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            fire = in_valid && in_ready;
            if (fire) rpn_predict(in_word);
            nxt_valid = in_valid && !fire;
            nxt_word  = in_word;
            if (!nxt_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0) begin
                    nxt_word  = pending_words.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end
            in_valid <= nxt_valid;
            in_word  <= nxt_word;
        end
    end

    // Receiver: ready follows a 32-bit pattern, redrawn with a random stall density.
    always @(posedge clk) begin
        if (ready_bits_left == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = '1;
                1: ready_pattern = $urandom();
                2: ready_pattern = $urandom() | $urandom();
                default: ready_pattern = $urandom() & $urandom() & $urandom();
            endcase
            ready_bits_left = 32;
        end
        out_ready <= ready_pattern[0];
        ready_pattern = ready_pattern >> 1;
        ready_bits_left--;
    end

    // Monitor: each accepted result is checked against the oldest expectation.
    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, value %0d status %0d",
                         $time, out_word.value, out_word.status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_word.value !== want.value) begin
                    $display("%0t: value mismatch, expected %0d actual %0d",
                             $time, want.value, out_word.value);
                    mismatch_count++;
                end
                if (out_word.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, out_word.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

// ===== rpn_stack_evaluator.f =====
+incdir+design
design/rse_pkg.sv
design/rse_muldiv.sv
design/rse_datapath.sv
design/rse_controller.sv
design/rpn_stack_evaluator.sv
design/rse_checker.sv
tb/sv/tb_rpn_stack_evaluator.sv
